>>> src/deq_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the double-ended queue core
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_ALL   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // cell update modes
  localparam logic [2:0] CELL_HOLD        = 3'd0;
  localparam logic [2:0] CELL_SHIFT_BACK  = 3'd1;
  localparam logic [2:0] CELL_SHIFT_FRONT = 3'd2;
  localparam logic [2:0] CELL_APPEND      = 3'd3;
  localparam logic [2:0] CELL_ROTATE      = 3'd4;

  typedef struct packed {
    logic [2:0]        mode;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> src/deq_cell.sv
`timescale 1ns / 1ps
// one storage cell of the queue chain
module deq_cell (
  input  logic                             clk,
  input  deq_pkg::cell_cmd_t               cmd,
  input  logic [deq_pkg::DATA_W-1:0]       prev_data,
  input  logic [deq_pkg::DATA_W-1:0]       next_data,
  input  logic [deq_pkg::DATA_W-1:0]       head_data,
  input  logic                             sel_tail,
  input  logic                             sel_append,
  output logic [deq_pkg::DATA_W-1:0]       data,
  output logic [deq_pkg::DATA_W-1:0]       tap
);

  logic [deq_pkg::DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.mode)
      deq_pkg::CELL_SHIFT_BACK:  data_next = prev_data;
      deq_pkg::CELL_SHIFT_FRONT: data_next = next_data;
      deq_pkg::CELL_APPEND:      if (sel_append) data_next = cmd.value;
      deq_pkg::CELL_ROTATE:      data_next = sel_tail ? head_data : next_data;
      default:                   data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // only the back entry drives the pop-back tap
  assign tap = sel_tail ? data : '0;

endmodule

>>> src/double_ended_queue_core.sv
`timescale 1ns / 1ps
// top level of the double-ended queue core: control, cell chain and result register
//
// usage
// - s_* channel takes one command item: s_tuser holds the operation, s_tdata the value
//   to push (ignored by other operations)
// - m_* channel gives result items: popped or read-out value, fill level, status in
//   m_tuser, m_tlast on the final result of a command
// - entries live in a row of cells, cell 0 the front; push-front and pop-front shift
//   the row, push-back writes the cell at the back, pop-back only lowers the count
// - push, pop and clear take one item per cycle while results are taken, result in the cycle after acceptance
// - read-all rotates the row once through the front cell, one entry per cycle while the
//   receiver takes them; the read state loads each entry into the result register, and
//   no new command is taken until the last entry has been loaded
// - a registered result stage lets a new command enter while the previous result is
//   taken in the same cycle
// - when the receiver stalls, the result holds and s_tready drops until it is taken
// - reset (rst, synchronous) empties the queue; cell contents are not cleared
module double_ended_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_value[31:0], fill_level[36:32], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  localparam logic [deq_pkg::CNT_W-1:0] FULL_CNT = deq_pkg::CNT_W'(deq_pkg::DEPTH);
  localparam logic [deq_pkg::CNT_W-1:0] ONE_CNT  = deq_pkg::CNT_W'(1);

  logic                           state;
  logic                           state_next;
  logic [deq_pkg::CNT_W-1:0]      count;
  logic [deq_pkg::CNT_W-1:0]      count_next;
  logic [deq_pkg::CNT_W-1:0]      rd_left;
  logic [deq_pkg::CNT_W-1:0]      rd_left_next;

  // result register
  logic [deq_pkg::DATA_W-1:0]     res_value;
  logic [deq_pkg::ST_W-1:0]       res_status;
  logic                           res_last;
  logic [deq_pkg::CNT_W-1:0]      res_fill;
  logic                           res_load;
  logic [deq_pkg::DATA_W-1:0]     res_value_next;
  logic [deq_pkg::ST_W-1:0]       res_status_next;
  logic                           res_last_next;

  logic                           out_free;
  logic                           in_acc;
  logic                           is_full;
  logic                           is_empty;
  logic [deq_pkg::OP_W-1:0]       op;

  deq_pkg::cell_cmd_t             cmd;
  logic [deq_pkg::DATA_W-1:0]     cell_data [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_W-1:0]     cell_tap  [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_W-1:0]     back_data;

  assign op       = s_tuser;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;
  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  // back entry collected from the cell taps
  always_comb begin
    back_data = '0;
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      back_data = back_data | cell_tap[i];
    end
  end

  // command decode: cell update mode, next count and the result of this item
  always_comb begin
    cmd.mode        = deq_pkg::CELL_HOLD;
    cmd.value       = s_tdata;
    count_next      = count;
    state_next      = state;
    rd_left_next    = rd_left;
    res_load        = 1'b0;
    res_value_next  = '0;
    res_status_next = deq_pkg::ST_OK;
    res_last_next   = 1'b1;

    if (in_acc) begin
      res_load = 1'b1;
      case (op)
        deq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            res_status_next = deq_pkg::ST_FULL;
          end else begin
            cmd.mode   = deq_pkg::CELL_SHIFT_BACK;
            count_next = count + ONE_CNT;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            res_status_next = deq_pkg::ST_FULL;
          end else begin
            cmd.mode   = deq_pkg::CELL_APPEND;
            count_next = count + ONE_CNT;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            res_status_next = deq_pkg::ST_EMPTY;
          end else begin
            cmd.mode       = deq_pkg::CELL_SHIFT_FRONT;
            res_value_next = cell_data[0];
            count_next     = count - ONE_CNT;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            res_status_next = deq_pkg::ST_EMPTY;
          end else begin
            res_value_next = back_data;
            count_next     = count - ONE_CNT;
          end
        end
        deq_pkg::OP_READ_ALL: begin
          if (is_empty) begin
            res_status_next = deq_pkg::ST_EMPTY;
          end else begin
            // results come from the rotation loop instead
            res_load     = 1'b0;
            state_next   = S_READ;
            rd_left_next = count;
          end
        end
        deq_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
          // unused codes leave the queue as it is
        end
      endcase
    end else if (state == S_READ && out_free) begin
      // emit the front entry and rotate it to the back of the occupied region
      cmd.mode       = deq_pkg::CELL_ROTATE;
      res_load       = 1'b1;
      res_value_next = cell_data[0];
      res_last_next  = (rd_left == ONE_CNT);
      rd_left_next   = rd_left - ONE_CNT;
      if (rd_left == ONE_CNT) begin
        state_next = S_IDLE;
      end
    end
  end

  // cell chain: cell 0 is the front, the back is cell count-1
  for (genvar g = 0; g < deq_pkg::DEPTH; g++) begin : g_cell
    localparam logic [deq_pkg::CNT_W-1:0] IDX_APP  = deq_pkg::CNT_W'(g);
    localparam logic [deq_pkg::CNT_W-1:0] IDX_TAIL = deq_pkg::CNT_W'(g + 1);
    logic [deq_pkg::DATA_W-1:0] prev_d;
    logic [deq_pkg::DATA_W-1:0] next_d;

    if (g == 0) begin : g_first
      assign prev_d = s_tdata;
    end else begin : g_mid_prev
      assign prev_d = cell_data[g-1];
    end

    if (g == deq_pkg::DEPTH - 1) begin : g_last
      assign next_d = cell_data[g];
    end else begin : g_mid_next
      assign next_d = cell_data[g+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .prev_data  (prev_d),
      .next_data  (next_d),
      .head_data  (cell_data[0]),
      .sel_tail   (count == IDX_TAIL),
      .sel_append (count == IDX_APP),
      .data       (cell_data[g]),
      .tap        (cell_tap[g])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_left  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_left <= rd_left_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_value  <= res_value_next;
      res_status <= res_status_next;
      res_last   <= res_last_next;
      res_fill   <= count_next;
    end
  end

  assign m_tdata = {{(40 - deq_pkg::DATA_W - deq_pkg::CNT_W){1'b0}}, res_fill, res_value};
  assign m_tuser = res_status;
  assign m_tlast = res_last;

  // fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above capacity");

  // a read-out in progress always has entries left to emit
  a_read_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rd_left != '0))
    else $error("read-out running with nothing left");

  // a push into a full queue leaves the count alone
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_full && (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK))
    |=> $stable(count))
    else $error("push into full queue changed the count");

  // final read-out entry returns the block to idle with tlast set
  a_read_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && out_free && rd_left == ONE_CNT)
    |=> (state == S_IDLE && m_tvalid && m_tlast))
    else $error("read-out did not end on its last entry");

  // commands are only taken while no read-out runs
  a_no_accept_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !in_acc)
    else $error("command accepted during read-out");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue core with a built-in deque predictor
module tb_top;
  import deq_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 450;
  localparam int SETTLE_CYCLES  = 40;    // read-all of a full queue plus result stage
  localparam int WATCHDOG_LIMIT = 3000;  // several times the longest quiet stretch
  localparam int RX_HOLD_AT     = 120;   // commands taken before the long result stall
  localparam int RX_HOLD_LEN    = 300;
  localparam int MAX_REPORTS    = 20;
  localparam int M_TDATA_W      = ((DATA_W + CNT_W + 7) / 8) * 8;

  // opcodes with no defined operation
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // random phase kinds
  localparam int PH_FILL  = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIXED = 2;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    bit                drain_first;  // sender waits for every result before this item
  } deq_cmd_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [ST_W-1:0]   status;
    logic              last;
    logic [CNT_W-1:0]  fill;
  } deq_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata  = '0;
  logic [OP_W-1:0]       s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [ST_W-1:0]       m_tuser;
  logic                  m_tlast;

  double_ended_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // value
    .s_tuser  (s_tuser),   // op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // result_value, fill_level, zero pad
    .m_tuser  (m_tuser),   // status
    .m_tlast  (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  deq_cmd_t    cmd_q[$];
  deq_result_t expected_results[$];
  deq_cmd_t    next_cmd;
  int          cmd_total;

  // predictor state: ring of entries, front position and occupancy
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int                head_pos = 0;
  int                held_cnt = 0;

  // run statistics
  int  op_seen [8];
  int  full_drops     = 0;
  int  empty_hits     = 0;
  int  peak_fill      = 0;
  int  results_seen   = 0;
  int  error_count    = 0;
  int  inputs_taken   = 0;
  bit  item_taken     = 1'b0;
  int  idle_cycles    = 0;

  // sender and receiver pacing
  int  tx_gap_left    = 0;
  bit  tx_burst       = 1'b0;
  int  rx_gap_left    = 0;
  bit  rx_burst       = 1'b0;
  int  rx_hold_left   = 0;
  bit  rx_hold_done   = 1'b0;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function void add_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                        input bit drain_first);
    deq_cmd_t c;
    c.op          = op;
    c.value       = value;
    c.drain_first = drain_first;
    cmd_q.push_back(c);
  endfunction

  function void expect_result(input logic [DATA_W-1:0] value, input logic [ST_W-1:0] status,
                              input logic last);
    deq_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    r.fill   = held_cnt[CNT_W-1:0];
    expected_results.push_back(r);
  endfunction

  // applies one command to the predicted deque and queues the results it causes
  function void predict_deque(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    int pos;
    int k;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_cnt >= DEPTH) begin
          full_drops++;
          expect_result('0, ST_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            pos = head_pos;
          end else begin
            pos = (head_pos + held_cnt) % DEPTH;
          end
          ring_mem[pos] = value;
          held_cnt++;
          if (held_cnt > peak_fill) peak_fill = held_cnt;
          expect_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held_cnt == 0) begin
          empty_hits++;
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (op == OP_POP_FRONT) begin
            pos = head_pos;
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            pos = (head_pos + held_cnt - 1) % DEPTH;
          end
          held_cnt--;
          expect_result(ring_mem[pos], ST_OK, 1'b1);
        end
      end
      OP_READ_ALL: begin
        if (held_cnt == 0) begin
          empty_hits++;
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (k = 0; k < held_cnt; k++)
            expect_result(ring_mem[(head_pos + k) % DEPTH], ST_OK, k == held_cnt - 1);
        end
      end
      OP_CLEAR: begin
        head_pos = 0;
        held_cnt = 0;
        expect_result('0, ST_OK, 1'b1);
      end
      default: begin
        expect_result('0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // result check first, then the command taken at this edge, so a result is never
  // matched against an expectation created in the same cycle
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result value=%h fill=%0d status=%0d last=%b", $time,
                   m_tdata[DATA_W-1:0], m_tdata[DATA_W +: CNT_W], m_tuser, m_tlast);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[DATA_W-1:0] !== want.value || m_tdata[DATA_W +: CNT_W] !== want.fill ||
            m_tdata[M_TDATA_W-1:DATA_W+CNT_W] !== '0 || m_tuser !== want.status ||
            m_tlast !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected value=%h fill=%0d status=%0d last=%b", $time,
                     want.value, want.fill, want.status, want.last);
            $display("%0t:          actual   value=%h fill=%0d status=%0d last=%b pad=%b",
                     $time, m_tdata[DATA_W-1:0], m_tdata[DATA_W +: CNT_W], m_tuser, m_tlast,
                     m_tdata[M_TDATA_W-1:DATA_W+CNT_W]);
          end
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      predict_deque(s_tuser, s_tdata);
      op_seen[s_tuser]++;
      inputs_taken++;
      item_taken = 1'b1;
    end
  end

  // command driver: holds an item until taken, then waits its gap and offers the next
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !item_taken) begin
      // item still on offer
    end else begin
      item_taken = 1'b0;
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        s_tvalid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (cmd_q[0].drain_first && expected_results.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        next_cmd = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_cmd.op;
        s_tdata  <= next_cmd.value;
        if (tx_burst || $urandom_range(0, 1) == 0) tx_gap_left = 0;
        else tx_gap_left = pick_gap();
      end
    end
  end

  // result receiver: random stalls plus one long hold-off while the sender keeps offering commands
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_hold_done && inputs_taken >= RX_HOLD_AT) begin
      rx_hold_done = 1'b1;
      rx_hold_left = RX_HOLD_LEN - 1;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!rx_burst && $urandom_range(0, 3) == 0) rx_gap_left = pick_gap();
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_results.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int phase_kind;
    int phase_len;
    int push_share;
    int r;
    logic [OP_W-1:0] op;

    // directed: empty cases, spare opcodes, extreme values at both ends, read-out, clear
    add_cmd(OP_CLEAR,      pick_value(),  1'b0);
    add_cmd(OP_POP_FRONT,  pick_value(),  1'b0);
    add_cmd(OP_POP_BACK,   pick_value(),  1'b0);
    add_cmd(OP_READ_ALL,   pick_value(),  1'b0);
    add_cmd(OP_SPARE_LO,   pick_value(),  1'b0);
    add_cmd(OP_SPARE_HI,   pick_value(),  1'b0);
    add_cmd(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
    add_cmd(OP_PUSH_BACK,  32'h7fff_ffff, 1'b0);
    add_cmd(OP_PUSH_FRONT, 32'hffff_ffff, 1'b0);
    add_cmd(OP_PUSH_BACK,  32'h0000_0000, 1'b0);
    add_cmd(OP_PUSH_BACK,  32'h5555_5555, 1'b0);
    add_cmd(OP_PUSH_FRONT, 32'haaaa_aaaa, 1'b0);
    add_cmd(OP_READ_ALL,   pick_value(),  1'b0);
    add_cmd(OP_POP_FRONT,  pick_value(),  1'b0);
    add_cmd(OP_POP_BACK,   pick_value(),  1'b0);
    add_cmd(OP_SPARE_LO,   pick_value(),  1'b0);
    add_cmd(OP_READ_ALL,   pick_value(),  1'b0);
    add_cmd(OP_CLEAR,      pick_value(),  1'b0);
    add_cmd(OP_READ_ALL,   pick_value(),  1'b0);
    add_cmd(OP_PUSH_BACK,  32'h0000_0001, 1'b0);
    add_cmd(OP_POP_FRONT,  pick_value(),  1'b0);

    // fill, drain and mixed random phases so full and empty are both reached
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(PH_FILL, PH_MIXED);
      phase_len  = $urandom_range(8, 40);
      push_share = (phase_kind == PH_FILL) ? 75 : (phase_kind == PH_DRAIN) ? 25 : 55;
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          op = OP_READ_ALL;
        end else if (r < 7 && phase_kind == PH_MIXED) begin
          op = OP_CLEAR;
        end else if (r < 8) begin
          op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
        end else if ($urandom_range(0, 99) < push_share) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        end
        // the sender drains the block before three of the items
        add_cmd(op, pick_value(), n == 0 || n == 200 || n == 380);
        n++;
      end
    end
    cmd_total = cmd_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (inputs_taken < cmd_total || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d commands: push %0d, pop %0d, read-all %0d, clear %0d, spare %0d",
             inputs_taken, op_seen[OP_PUSH_FRONT] + op_seen[OP_PUSH_BACK],
             op_seen[OP_POP_FRONT] + op_seen[OP_POP_BACK], op_seen[OP_READ_ALL],
             op_seen[OP_CLEAR], op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI]);
    $display("%0d results checked, %0d dropped pushes, %0d empty hits, peak fill %0d, %0d errors",
             results_seen, full_drops, empty_hits, peak_fill, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
